### rtl/mahs_pkg.sv
// Shared constants and register codes for the moving average hysteresis switch.
`timescale 1ns / 1ps
`default_nettype none

package mahs_pkg;

    localparam int WINDOW    = 10;
    localparam int SMP_W     = 12;
    localparam int SUM_W     = 16;
    localparam int PTR_W     = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int CNT_W     = $clog2(WINDOW + 1);
    localparam int STEP_W    = $clog2(SUM_W);
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] REG_DARK  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_LIGHT = CFG_IDX_W'(1);

    localparam logic [SMP_W-1:0] DARK_RESET  = SMP_W'(1500);
    localparam logic [SMP_W-1:0] LIGHT_RESET = SMP_W'(1900);
    localparam logic [SMP_W-1:0] AVG_MAX     = {SMP_W{1'b1}};

endpackage

`default_nettype wire

### rtl/mahs_div.sv
// Restoring divider of the running sum by the fill count, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none

module mahs_div
    import mahs_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [SUM_W-1:0] i_dividend,
    input  wire logic [CNT_W-1:0] i_divisor,
    output logic                  o_done,
    output logic [SUM_W-1:0]      o_quotient
);

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_step;
    logic [SUM_W-1:0]  r_quo;
    logic [CNT_W-1:0]  r_rem;
    logic [CNT_W-1:0]  r_div;

    logic [CNT_W:0]    rem_shift;
    logic [CNT_W:0]    rem_diff;
    logic              fits;

    assign rem_shift = {r_rem, r_quo[SUM_W-1]};
    assign rem_diff  = rem_shift - {1'b0, r_div};
    assign fits      = rem_shift >= {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
            r_quo  <= '0;
            r_rem  <= '0;
            r_div  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
                r_quo  <= i_dividend;
                r_rem  <= '0;
                r_div  <= i_divisor;
            end else if (r_busy) begin
                r_quo <= {r_quo[SUM_W-2:0], fits};
                r_rem <= fits ? rem_diff[CNT_W-1:0] : rem_shift[CNT_W-1:0];
                r_step <= r_step + STEP_W'(1);
                if (r_step == STEP_W'(SUM_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

`default_nettype wire

### rtl/moving_average_hysteresis_switch.sv
// Top level: sample ring memory, running sum, fill count and hysteresis switch.
//
// Usage:
//   Input channel i_valid/o_ready carries one 12-bit light sample per request.
//   Output channel o_valid/i_ready carries average, output_on and changed,
//   exactly one result per accepted sample, in order.
//   Configuration: i_cfg_we writes i_cfg_data into register i_cfg_index
//   (0 dark threshold, 1 light threshold) at the clock edge, no wait.
//   Path: an accepted sample updates sum and count in S_UPDATE, then the
//   16-step serial divider of the sum by the fill count runs in S_DIV, and
//   S_OUT loads the output register. The block takes one sample at a time
//   and is ready again once the result is in the output register.
//   Stall: a result waits in the output register while i_ready is low; the
//   next sample may be accepted meanwhile and its result waits for that
//   register to free.
//   Reset (synchronous, i_rst_n low): ring empty, sum and count zero, switch
//   off, thresholds 1500 and 1900. No clearing pass: ring entries are read
//   only after they were written.
`timescale 1ns / 1ps
`default_nettype none

module moving_average_hysteresis_switch
    import mahs_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    output logic                      o_ready,
    input  wire logic [SMP_W-1:0]     i_sample,
    output logic                      o_valid,
    input  wire logic                 i_ready,
    output logic [SMP_W-1:0]          o_average,
    output logic                      o_output_on,
    output logic                      o_changed,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [SMP_W-1:0]     i_cfg_data
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_UPDATE,
        S_DIV,
        S_OUT
    } t_state;

    t_state            r_state;
    logic [SMP_W-1:0]  r_sample;
    logic [PTR_W-1:0]  r_ptr;
    logic [CNT_W-1:0]  r_count;
    logic [SUM_W-1:0]  r_sum;
    logic              r_switch;
    logic [SMP_W-1:0]  r_dark;
    logic [SMP_W-1:0]  r_light;
    logic              r_valid;
    logic [SMP_W-1:0]  r_average;
    logic              r_on;
    logic              r_changed;

    logic [SMP_W-1:0]  r_ring [WINDOW];
    logic [SMP_W-1:0]  r_rd_data;

    logic              accept;
    logic              full;
    logic [SUM_W-1:0]  n_sum;
    logic [CNT_W-1:0]  n_count;
    logic [PTR_W-1:0]  n_ptr;
    logic              div_done;
    logic [SUM_W-1:0]  div_quo;
    logic [SMP_W-1:0]  avg;
    logic              n_on;
    logic              n_changed;
    logic              out_free;

    assign accept   = i_valid && (r_state == S_IDLE);
    assign full     = r_count == CNT_W'(WINDOW);
    assign n_sum    = r_sum - (full ? SUM_W'(r_rd_data) : SUM_W'(0)) + SUM_W'(r_sample);
    assign n_count  = full ? r_count : r_count + CNT_W'(1);
    assign n_ptr    = (r_ptr == PTR_W'(WINDOW - 1)) ? '0 : r_ptr + PTR_W'(1);
    assign out_free = !r_valid || i_ready;

    assign avg = (|div_quo[SUM_W-1:SMP_W]) ? AVG_MAX : div_quo[SMP_W-1:0];

    always_comb begin
        n_on      = r_switch;
        n_changed = 1'b0;
        if (!r_switch && (avg < r_dark)) begin
            n_on      = 1'b1;
            n_changed = 1'b1;
        end else if (r_switch && (avg > r_light)) begin
            n_on      = 1'b0;
            n_changed = 1'b1;
        end
    end

    mahs_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_state == S_UPDATE),
        .i_dividend (n_sum),
        .i_divisor  (n_count),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    always_ff @(posedge i_clk) begin
        if (r_state == S_UPDATE) begin
            r_ring[r_ptr] <= r_sample;
        end
        if (accept) begin
            r_rd_data <= r_ring[r_ptr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dark  <= DARK_RESET;
            r_light <= LIGHT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_DARK:  r_dark  <= i_cfg_data;
                REG_LIGHT: r_light <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_sample  <= '0;
            r_ptr     <= '0;
            r_count   <= '0;
            r_sum     <= '0;
            r_switch  <= 1'b0;
            r_valid   <= 1'b0;
            r_average <= '0;
            r_on      <= 1'b0;
            r_changed <= 1'b0;
        end else begin
            if (r_valid && i_ready && (r_state != S_OUT)) begin
                r_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_sample <= i_sample;
                        r_state  <= S_UPDATE;
                    end
                end
                S_UPDATE: begin
                    r_sum   <= n_sum;
                    r_count <= n_count;
                    r_ptr   <= n_ptr;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (div_done) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (out_free) begin
                        r_valid   <= 1'b1;
                        r_average <= avg;
                        r_on      <= n_on;
                        r_changed <= n_changed;
                        r_switch  <= n_on;
                        r_state   <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_ready     = r_state == S_IDLE;
    assign o_valid     = r_valid;
    assign o_average   = r_average;
    assign o_output_on = r_on;
    assign o_changed   = r_changed;

endmodule

`default_nettype wire

### rtl/mahs_checker.sv
// Port-level checks for the moving average hysteresis switch, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module mahs_checker
    import mahs_pkg::*;
(
    input wire logic                 i_clk,
    input wire logic                 i_rst_n,
    input wire logic                 i_valid,
    input wire logic                 o_ready,
    input wire logic                 o_valid,
    input wire logic                 i_ready,
    input wire logic [SMP_W-1:0]     o_average,
    input wire logic                 o_output_on,
    input wire logic                 o_changed
);

    a_reset_clean: assert property (@(posedge i_clk)
        !i_rst_n |=> o_ready && !o_valid)
        else $error("block not idle after reset");

    a_result_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_average)
            && $stable(o_output_on) && $stable(o_changed))
        else $error("stalled result changed");

    a_busy_after_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("ready stayed high after an accepted request");

    a_idle_stays: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready && !i_valid |=> o_ready)
        else $error("ready dropped without a request");

    a_turn_on_below_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_changed && o_output_on |-> o_average != AVG_MAX)
        else $error("switch turned on at full-scale average");

endmodule

bind moving_average_hysteresis_switch mahs_checker u_mahs_checker (.*);

`default_nettype wire
